// ----- src/mbah_pkg.sv -----
// Shared widths, register indexes and the arctangent table of the heading core.
package mbah_pkg;

    // Field and register widths
    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 8;
    localparam int ACC_W     = 24;
    localparam int CNT_W     = 8;
    localparam int GAIN_W    = 16;
    localparam int FIELD_W   = 23;
    localparam int HEAD_W    = 17;
    localparam int MAG_W     = 23;

    // Stream packing
    localparam int IN_TDATA_W  = ((3 * SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_BITS    = 3 * FIELD_W + HEAD_W + MAG_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int HEAD_LSB    = 3 * FIELD_W;
    localparam int MAG_LSB     = HEAD_LSB + HEAD_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd1;
    localparam logic [CNT_W-1:0]  AVG_RESET  = 8'd10;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd19857;

    // Serial multiplier, divider and square root
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 24;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int DIV_W    = FRAC_BITS + 26;
    localparam int WIDE_W   = PROD_W + FRAC_BITS + 1;
    localparam int FIELD_RND_SH = 15;
    localparam int MAG_RND_SH   = 22;
    localparam int SUMSQ_W  = 48;
    localparam int SQ_SHIFT = 14;
    localparam int SQ_IN_W  = SUMSQ_W + SQ_SHIFT;
    localparam int ROOT_W   = SQ_IN_W / 2;

    // Saturation limits
    localparam logic [DIV_W-1:0] FIELD_POS_MAX = DIV_W'((64'd1 << (FIELD_W - 1)) - 64'd1);
    localparam logic [DIV_W-1:0] FIELD_NEG_MAX = DIV_W'(64'd1 << (FIELD_W - 1));
    localparam logic [DIV_W-1:0] MAG_MAX       = DIV_W'((64'd1 << MAG_W) - 64'd1);

    // Heading CORDIC, angles in units of 2^-24 degree
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W  = 5;
    localparam int ANG_W   = 30;
    localparam int CX_SH   = 30;
    localparam int CX_W    = ACC_W + CX_SH + 3;
    localparam int CZ_W    = 35;
    localparam int HEAD_SH = 24 - FRAC_BITS;
    localparam logic [CZ_W-1:0] Z_HALF_TURN = CZ_W'(64'd180 << 24);
    localparam logic [CZ_W-1:0] Z_FULL_TURN = CZ_W'(64'd360 << 24);
    localparam logic [CZ_W-1:0] Z_HEAD_RND  = CZ_W'(64'd1 << (HEAD_SH - 1));
    localparam logic [CZ_W-1:0] Z_HEAD_TURN = CZ_W'(64'd360 << FRAC_BITS);
    localparam logic [CZ_W-1:0] Z_HEAD_MAX  = CZ_W'((64'd1 << HEAD_W) - 64'd1);
    localparam int HEAD_TURN = 360 << FRAC_BITS;

    typedef logic [ANG_W-1:0] t_ang;

    // atan(2^-i) in units of 2^-24 degree
    function automatic t_ang atan_deg(input logic [STEP_W-1:0] i);
        t_ang a;
        unique case (i)
            5'd0:    a = 30'd754974720;
            5'd1:    a = 30'd445687602;
            5'd2:    a = 30'd235489088;
            5'd3:    a = 30'd119537938;
            5'd4:    a = 30'd60000934;
            5'd5:    a = 30'd30029717;
            5'd6:    a = 30'd15018523;
            5'd7:    a = 30'd7509720;
            5'd8:    a = 30'd3754917;
            5'd9:    a = 30'd1877466;
            5'd10:   a = 30'd938734;
            5'd11:   a = 30'd469367;
            5'd12:   a = 30'd234684;
            5'd13:   a = 30'd117342;
            5'd14:   a = 30'd58671;
            5'd15:   a = 30'd29335;
            5'd16:   a = 30'd14668;
            5'd17:   a = 30'd7334;
            5'd18:   a = 30'd3667;
            5'd19:   a = 30'd1833;
            5'd20:   a = 30'd917;
            5'd21:   a = 30'd458;
            5'd22:   a = 30'd229;
            5'd23:   a = 30'd115;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- src/magnetometer_block_average_heading_core.sv -----
// Top level: block accumulation, result sequencer and the output register.
//
// Channel   | Dir | Fields (lowest bit up)
// s_axis    | in  | x_sample, z_sample, y_sample (16 bits each, signed)
// m_axis    | out | x_field, y_field, z_field (23 signed), heading_deg (17), magnitude (23)
// i_cfg_*   | in  | index 0 average_count, index 1 gain_q16
//
// A sample that does not close a block is accepted without holding tready low.
// A sample that closes a block holds tready low while the bit-serial
// multiplier and divider (Q8 results) run four times in turn, with the
// squares and the square root before the last run, plus any wait for
// m_axis to take the previous result. The heading CORDIC runs alongside.
// Reset is synchronous, active low.
// A result waiting on m_axis does not stop accumulation of the next block.
module magnetometer_block_average_heading_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [mbah_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mbah_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // x_sample, z_sample, y_sample
    input  logic [mbah_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // x_field, y_field, z_field, heading_deg, magnitude, zero padding
    output logic [mbah_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import mbah_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_SQR  = 6'b001000,
        ST_SQRT = 6'b010000,
        ST_WAIT = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        SL_X   = 2'd0,
        SL_Y   = 2'd1,
        SL_Z   = 2'd2,
        SL_MAG = 2'd3
    } t_slot;

    function automatic logic [ACC_W-1:0] abs_acc(input logic [ACC_W-1:0] v);
        return v[ACC_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [FIELD_W-1:0] sat_field(input logic [DIV_W-1:0] q,
                                                    input logic neg);
        logic [FIELD_W-1:0] m;
        if (neg) begin
            m = (q > FIELD_NEG_MAX) ? FIELD_NEG_MAX[FIELD_W-1:0] : q[FIELD_W-1:0];
            return -m;
        end
        m = (q > FIELD_POS_MAX) ? FIELD_POS_MAX[FIELD_W-1:0] : q[FIELD_W-1:0];
        return m;
    endfunction

    t_state r_state, n_state;
    t_slot  r_slot, n_slot;
    t_slot  r_sq, n_sq;

    logic [CNT_W-1:0]   r_avg;
    logic [GAIN_W-1:0]  r_gain;
    logic [ACC_W-1:0]   r_acc_x, r_acc_y, r_acc_z;
    logic [CNT_W-1:0]   r_count;
    logic [ACC_W-1:0]   r_sx, r_sy, r_sz;
    logic [CNT_W-1:0]   r_n;
    logic [SUMSQ_W-1:0] r_sumsq, n_sumsq;
    logic [FIELD_W-1:0] r_xf, r_yf, r_zf;
    logic [MAG_W-1:0]   r_mag;
    logic               r_head_ok;
    logic               r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [SAMPLE_W-1:0] w_x_in, w_z_in, w_y_in;
    logic [ACC_W-1:0]    n_acc_x, n_acc_y, n_acc_z;
    logic [CNT_W-1:0]    w_n_eff, w_cnt_next;
    logic                w_accept, w_emit;

    logic                mul_start, mul_done;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_prod;
    logic                div_start, div_done;
    logic [DIV_W-1:0]    div_dividend, div_quot;
    logic                sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]   sqrt_root;
    logic                cordic_start, cordic_done;
    logic [HEAD_W-1:0]   cordic_head;
    logic                w_store, w_load;
    logic [WIDE_W-1:0]   w_num_field, w_num_mag;
    logic [ACC_W-1:0]    w_slot_sum;

    // Unpack the request and extend the samples to the sum width
    assign w_x_in  = s_axis_tdata[0*SAMPLE_W +: SAMPLE_W];
    assign w_z_in  = s_axis_tdata[1*SAMPLE_W +: SAMPLE_W];
    assign w_y_in  = s_axis_tdata[2*SAMPLE_W +: SAMPLE_W];
    assign n_acc_x = r_acc_x + {{(ACC_W - SAMPLE_W){w_x_in[SAMPLE_W-1]}}, w_x_in};
    assign n_acc_y = r_acc_y + {{(ACC_W - SAMPLE_W){w_y_in[SAMPLE_W-1]}}, w_y_in};
    assign n_acc_z = r_acc_z + {{(ACC_W - SAMPLE_W){w_z_in[SAMPLE_W-1]}}, w_z_in};

    // Close the block when the count reaches the length or wraps
    assign w_n_eff    = (r_avg == '0) ? CNT_W'(1) : r_avg;
    assign w_cnt_next = r_count + 1'b1;
    assign w_emit     = (w_cnt_next >= w_n_eff) || (w_cnt_next == '0);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Rounded numerators ahead of the division by the block length
    assign w_num_field  = (WIDE_W'(mul_prod) << FRAC_BITS) + (WIDE_W'(r_n) << FIELD_RND_SH);
    assign w_num_mag    = (WIDE_W'(mul_prod) << FRAC_BITS) + (WIDE_W'(r_n) << MAG_RND_SH);
    assign div_dividend = (r_slot == SL_MAG) ? DIV_W'(w_num_mag >> (MAG_RND_SH + 1))
                                             : DIV_W'(w_num_field >> (FIELD_RND_SH + 1));

    always_comb begin
        unique case (r_slot)
            SL_X:    w_slot_sum = r_sx;
            SL_Y:    w_slot_sum = r_sy;
            SL_Z:    w_slot_sum = r_sz;
            default: w_slot_sum = '0;
        endcase
    end

    // Sequencer: three axis fields, the sum of squares, its root, then the magnitude
    always_comb begin
        n_state      = r_state;
        n_slot       = r_slot;
        n_sq         = r_sq;
        n_sumsq      = r_sumsq;
        mul_start    = 1'b0;
        mul_a        = MUL_A_W'(abs_acc(r_sx));
        mul_b        = MUL_B_W'(r_gain);
        div_start    = 1'b0;
        sqrt_start   = 1'b0;
        cordic_start = 1'b0;
        w_store      = 1'b0;
        w_load       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_emit) begin
                    mul_start    = 1'b1;
                    mul_a        = MUL_A_W'(abs_acc(n_acc_x));
                    cordic_start = 1'b1;
                    n_slot       = SL_X;
                    n_sumsq      = '0;
                    n_state      = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    w_store = 1'b1;
                    unique case (r_slot)
                        SL_X: begin
                            mul_start = 1'b1;
                            mul_a     = MUL_A_W'(abs_acc(r_sy));
                            n_slot    = SL_Y;
                            n_state   = ST_MUL;
                        end
                        SL_Y: begin
                            mul_start = 1'b1;
                            mul_a     = MUL_A_W'(abs_acc(r_sz));
                            n_slot    = SL_Z;
                            n_state   = ST_MUL;
                        end
                        SL_Z: begin
                            mul_start = 1'b1;
                            mul_a     = MUL_A_W'(abs_acc(r_sx));
                            mul_b     = MUL_B_W'(abs_acc(r_sx));
                            n_sq      = SL_X;
                            n_state   = ST_SQR;
                        end
                        default: begin
                            n_state = ST_WAIT;
                        end
                    endcase
                end
            end
            ST_SQR: begin
                if (mul_done) begin
                    n_sumsq = r_sumsq + SUMSQ_W'(mul_prod);
                    unique case (r_sq)
                        SL_X: begin
                            mul_start = 1'b1;
                            mul_a     = MUL_A_W'(abs_acc(r_sy));
                            mul_b     = MUL_B_W'(abs_acc(r_sy));
                            n_sq      = SL_Y;
                        end
                        SL_Y: begin
                            mul_start = 1'b1;
                            mul_a     = MUL_A_W'(abs_acc(r_sz));
                            mul_b     = MUL_B_W'(abs_acc(r_sz));
                            n_sq      = SL_Z;
                        end
                        default: begin
                            sqrt_start = 1'b1;
                            n_state    = ST_SQRT;
                        end
                    endcase
                end
            end
            ST_SQRT: begin
                if (sqrt_done) begin
                    mul_start = 1'b1;
                    mul_a     = MUL_A_W'(sqrt_root);
                    n_slot    = SL_MAG;
                    n_state   = ST_MUL;
                end
            end
            ST_WAIT: begin
                if (r_head_ok && (!r_out_valid || m_axis_tready)) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state: configuration, accumulators, sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= SL_X;
            r_sq        <= SL_X;
            r_avg       <= AVG_RESET;
            r_gain      <= GAIN_RESET;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_acc_z     <= '0;
            r_count     <= '0;
            r_head_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_sq    <= n_sq;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_AVG_COUNT: r_avg  <= i_cfg_wdata[CNT_W-1:0];
                    CFG_GAIN:      r_gain <= i_cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                if (w_emit) begin
                    r_acc_x <= '0;
                    r_acc_y <= '0;
                    r_acc_z <= '0;
                    r_count <= '0;
                end else begin
                    r_acc_x <= n_acc_x;
                    r_acc_y <= n_acc_y;
                    r_acc_z <= n_acc_z;
                    r_count <= w_cnt_next;
                end
            end
            if (cordic_start) begin
                r_head_ok <= 1'b0;
            end else if (cordic_done) begin
                r_head_ok <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: block snapshot, finished fields and the output register
    always_ff @(posedge i_clk) begin
        r_sumsq <= n_sumsq;
        if (cordic_start) begin
            r_sx <= n_acc_x;
            r_sy <= n_acc_y;
            r_sz <= n_acc_z;
            r_n  <= w_n_eff;
        end
        if (w_store) begin
            unique case (r_slot)
                SL_X:    r_xf  <= sat_field(div_quot, w_slot_sum[ACC_W-1]);
                SL_Y:    r_yf  <= sat_field(div_quot, w_slot_sum[ACC_W-1]);
                SL_Z:    r_zf  <= sat_field(div_quot, w_slot_sum[ACC_W-1]);
                default: r_mag <= (div_quot > MAG_MAX) ? MAG_MAX[MAG_W-1:0]
                                                       : div_quot[MAG_W-1:0];
            endcase
        end
        if (w_load) begin
            r_out_data <= OUT_TDATA_W'({r_mag, cordic_head, r_zf, r_yf, r_xf});
        end
    end

    mbah_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    mbah_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    mbah_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value ({n_sumsq, {SQ_SHIFT{1'b0}}}),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    mbah_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cordic_start),
        .i_sx      (n_acc_x),
        .i_sy      (n_acc_y),
        .i_zero    (((n_acc_x == '0) && (n_acc_y == '0)) || (r_gain == '0)),
        .o_done    (cordic_done),
        .o_heading (cordic_head)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- src/mbah_mul.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module mbah_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mbah_pkg::MUL_A_W-1:0]  i_a,
    input  logic [mbah_pkg::MUL_B_W-1:0]  i_b,
    output logic                          o_done,
    output logic [mbah_pkg::PROD_W-1:0]   o_prod
);
    import mbah_pkg::*;

    localparam int MCNT_W = $clog2(MUL_B_W);

    logic              r_busy;
    logic              r_done;
    logic [MCNT_W-1:0] r_cnt;
    logic [PROD_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [PROD_W-1:0] r_acc;

    // Control: run for one pass over the multiplier bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MCNT_W'(MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: add the shifted multiplicand where the multiplier bit is set
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= PROD_W'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ----- src/mbah_div.sv -----
// Restoring divider by the block length, one quotient bit per cycle.
module mbah_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mbah_pkg::DIV_W-1:0]  i_dividend,
    input  logic [mbah_pkg::CNT_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [mbah_pkg::DIV_W-1:0]  o_quot
);
    import mbah_pkg::*;

    localparam int DCNT_W = $clog2(DIV_W);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_den;
    logic [CNT_W:0]    w_trial;
    logic              w_ge;
    logic [CNT_W:0]    w_diff;

    // One restoring step: bring down the next dividend bit
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ----- src/mbah_isqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
module mbah_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mbah_pkg::SQ_IN_W-1:0]  i_value,
    output logic                          o_done,
    output logic [mbah_pkg::ROOT_W-1:0]   o_root
);
    import mbah_pkg::*;

    localparam int REM_W  = ROOT_W + 3;
    localparam int SCNT_W = $clog2(ROOT_W);

    logic              r_busy;
    logic              r_done;
    logic [SCNT_W-1:0] r_cnt;
    logic [SQ_IN_W-1:0] r_val;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  w_pos;
    logic [REM_W-1:0]  w_trial;
    logic              w_ge;

    // Bring down two radicand bits and try the next root bit
    assign w_pos   = {r_rem[REM_W-3:0], r_val[SQ_IN_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = w_pos >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SCNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= r_val << 2;
            r_rem  <= w_ge ? (w_pos - w_trial) : w_pos;
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- src/mbah_cordic.sv -----
// Vectoring CORDIC for the compass heading, one rotation per cycle.
module mbah_cordic (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mbah_pkg::ACC_W-1:0]  i_sx,
    input  logic [mbah_pkg::ACC_W-1:0]  i_sy,
    input  logic                        i_zero,
    output logic                        o_done,
    output logic [mbah_pkg::HEAD_W-1:0] o_heading
);
    import mbah_pkg::*;

    logic                   r_busy;
    logic                   r_fin;
    logic                   r_done;
    logic [STEP_W-1:0]      r_step;
    logic                   r_zero;
    logic signed [CX_W-1:0] r_x;
    logic signed [CX_W-1:0] r_y;
    logic [CZ_W-1:0]        r_z;
    logic [HEAD_W-1:0]      r_head;

    logic signed [CX_W-1:0] w_x0;
    logic signed [CX_W-1:0] w_y0;
    logic signed [CX_W-1:0] w_xs;
    logic signed [CX_W-1:0] w_ys;
    logic [CZ_W-1:0]        w_ang;
    logic                   w_ypos;
    logic [CZ_W-1:0]        w_zw;
    logic [CZ_W-1:0]        w_code;
    logic [CZ_W-1:0]        w_code2;
    logic [HEAD_W-1:0]      w_head;

    // Scale the sums up so the shifts keep their fraction
    assign w_x0   = {{(CX_W - ACC_W - CX_SH){i_sx[ACC_W-1]}}, i_sx, {CX_SH{1'b0}}};
    assign w_y0   = {{(CX_W - ACC_W - CX_SH){i_sy[ACC_W-1]}}, i_sy, {CX_SH{1'b0}}};
    assign w_xs   = r_x >>> r_step;
    assign w_ys   = r_y >>> r_step;
    assign w_ang  = CZ_W'(atan_deg(r_step));
    assign w_ypos = !r_y[CX_W-1] && (r_y != '0);

    // Wrap the angle into one turn, round to the output step and saturate
    always_comb begin
        if (r_z[CZ_W-1]) begin
            w_zw = r_z + Z_FULL_TURN;
        end else if (r_z >= Z_FULL_TURN) begin
            w_zw = r_z - Z_FULL_TURN;
        end else begin
            w_zw = r_z;
        end
        w_code  = (w_zw + Z_HEAD_RND) >> HEAD_SH;
        w_code2 = (w_code >= Z_HEAD_TURN) ? (w_code - Z_HEAD_TURN) : w_code;
        if (r_zero) begin
            w_head = '0;
        end else if (w_code2 > Z_HEAD_MAX) begin
            w_head = Z_HEAD_MAX[HEAD_W-1:0];
        end else begin
            w_head = w_code2[HEAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    // Rotate towards the positive X axis; start from the left half-plane flipped
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= i_zero;
            if (i_sx[ACC_W-1]) begin
                r_x <= -w_x0;
                r_y <= -w_y0;
                r_z <= Z_HALF_TURN;
            end else begin
                r_x <= w_x0;
                r_y <= w_y0;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (w_ypos) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_ang;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_ang;
            end
        end
        if (r_fin) begin
            r_head <= w_head;
        end
    end

    assign o_done    = r_done;
    assign o_heading = r_head;

endmodule

// ----- src/mbah_checker.sv -----
// Port-level checks on the heading core and their bind to the top level.
module mbah_props (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [mbah_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import mbah_pkg::*;

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A new result only appears after the block computation held requests off
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a computation phase");

    // Heading stays below a full turn
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (int'(m_axis_tdata[HEAD_LSB +: HEAD_W]) < HEAD_TURN))
        else $error("heading out of range");

endmodule

bind magnetometer_block_average_heading_core mbah_props u_mbah_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
